/* hw/rtl/bmmd_pkg.sv */
// Package for the banked memory map decoder: access kinds, map constants,
// the front-to-back queue entry type. No dependencies.
package bmmd_pkg;

    typedef enum logic [2:0] {
        K_READ     = 3'd0,
        K_WRITE    = 3'd1,
        K_LOAD_ROM = 3'd2,
        K_LOAD_DSK = 3'd3,
        K_SET_KBD  = 3'd4
    } t_kind;

    localparam int AW = 16;
    localparam int RAM_PAGE_DEPTH = 65536;
    localparam int ROM_DEPTH = 2048;
    localparam int ROM_DISK_DEPTH = 65536;
    localparam int ROM_AW = $clog2(ROM_DEPTH);
    localparam int DSK_AW = $clog2(ROM_DISK_DEPTH);
    localparam int RAM_AW = $clog2(RAM_PAGE_DEPTH);

    localparam logic [15:0] AREA_MASK = 16'hFC00;
    localparam logic [15:0] AREA_RAM0 = 16'hF000;
    localparam logic [15:0] AREA_PORT = 16'hF400;
    localparam logic [15:0] AREA_CTRL = 16'hF800;
    localparam logic [15:0] AREA_NONE = 16'hFC00;
    localparam logic [7:0]  BYTE_FF   = 8'hFF;
    localparam logic [31:0] WORD_FF   = 32'hFFFF_FFFF;

    // Decoded class of one beat.
    typedef enum logic [3:0] {
        C_NONE, C_RD_ROM, C_RD_RAM0, C_RD_RAM1, C_RD_PORT, C_RD_FF,
        C_WR_RAM0, C_WR_RAM1, C_WR_PORT, C_WR_CTRL, C_LD_ROM, C_LD_DSK,
        C_SET_KBD, C_WR_DROP
    } t_cls;

    typedef struct packed {
        t_cls        cls;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        vid_hit;
    } t_entry;

endpackage

/* hw/rtl/banked_memory_map_decoder.sv */
// Top level of the banked memory map decoder: front classifier and back
// executor joined by a one-entry register. Depends on bmmd_pkg, bmmd_front, bmmd_back.
//
//  Channel   Direction  Handshake          Payload
//  access    in         start & !busy      i_kind, i_address, i_write_data
//  result    out        o_result_valid     o_read_data ... o_keyboard_out_port
//
// A beat passes the front register, back execute and result steps; a write to the
// ROM disk port adds a fetch step because the disk memory read is registered.
// After reset the two RAM pages are cleared while busy is high.
// Results show for one cycle and cannot be stalled.
module banked_memory_map_decoder import bmmd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic        o_result_valid,
    output logic [7:0]  o_read_data,
    output logic [15:0] o_video_address,
    output logic        o_keyboard_written,
    output logic        o_video_mode_written,
    output logic        o_ram_page_written,
    output logic        o_video_buffer_written,
    output logic [7:0]  o_video_mode,
    output logic [7:0]  o_video_buffer,
    output logic [31:0] o_keyboard_out_port
);
    logic   r_busy;
    logic   take, f_valid, boot_done, clearing, done;
    logic [1:0] page, vbuf;
    t_entry entry;

    assign take = start && !busy;
    assign busy = r_busy || clearing;

    // One beat in flight: the front's classification reads state the back
    // updates, so the next beat waits for the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    bmmd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take),
        .i_kind(i_kind), .i_address(i_address), .i_write_data(i_write_data),
        .i_boot_done(boot_done), .i_page(page), .i_vbuf(vbuf),
        .o_valid(f_valid), .o_entry(entry)
    );

    bmmd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .i_entry(entry),
        .o_boot_done(boot_done), .o_page(page), .o_vbuf(vbuf),
        .o_clearing(clearing), .o_done(done),
        .o_read_data(o_read_data), .o_video_address(o_video_address),
        .o_keyboard_written(o_keyboard_written),
        .o_video_mode_written(o_video_mode_written),
        .o_ram_page_written(o_ram_page_written),
        .o_video_buffer_written(o_video_buffer_written),
        .o_video_mode(o_video_mode), .o_video_buffer(o_video_buffer),
        .o_keyboard_out_port(o_keyboard_out_port)
    );

    assign o_result_valid = done;
endmodule

/* hw/rtl/bmmd_front.sv */
// Front part: accepts beats and classifies them against the address map.
// Depends on bmmd_pkg; reads boot/page/video-buffer state from the back part.
module bmmd_front import bmmd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_boot_done,
    input  logic [1:0]  i_page,
    input  logic [1:0]  i_vbuf,
    output logic        o_valid,
    output t_entry      o_entry
);
    logic   r_valid;
    t_entry r_entry, n_entry;
    logic [15:0] area;

    always_comb begin
        area = i_address & AREA_MASK;
        n_entry.addr = i_address;
        n_entry.data = i_write_data;
        n_entry.vid_hit = (i_address[15:14] == ~i_vbuf) && (i_address[13:12] != 2'b11);
        n_entry.cls = C_NONE;
        unique case (i_kind)
            K_READ: begin
                if (!i_boot_done) n_entry.cls = C_RD_ROM;
                else if (area == AREA_RAM0) n_entry.cls = C_RD_RAM0;
                else if (area == AREA_PORT) n_entry.cls = C_RD_PORT;
                else if (area == AREA_CTRL || area == AREA_NONE) n_entry.cls = C_RD_ROM;
                else if (i_page == 2'd0) n_entry.cls = C_RD_RAM0;
                else if (i_page == 2'd1) n_entry.cls = C_RD_RAM1;
                else n_entry.cls = C_RD_FF;
            end
            K_WRITE: begin
                if (area == AREA_RAM0) n_entry.cls = C_WR_RAM0;
                else if (area == AREA_PORT) n_entry.cls = C_WR_PORT;
                else if (area == AREA_CTRL) n_entry.cls = C_WR_CTRL;
                else if (area == AREA_NONE) n_entry.cls = C_NONE;
                else if (i_page == 2'd0) n_entry.cls = C_WR_RAM0;
                else if (i_page == 2'd1) n_entry.cls = C_WR_RAM1;
                else n_entry.cls = C_WR_DROP;
            end
            K_LOAD_ROM: n_entry.cls = C_LD_ROM;
            K_LOAD_DSK: n_entry.cls = C_LD_DSK;
            K_SET_KBD:  n_entry.cls = C_SET_KBD;
            default:    n_entry.cls = C_NONE;
        endcase
        if (i_kind != K_WRITE || area >= AREA_RAM0) n_entry.vid_hit = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
        if (i_take) begin
            r_entry <= n_entry;
        end
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;
endmodule

/* hw/rtl/bmmd_back.sv */
// Back part: holds RAM, ROM, ROM disk and the port/control registers and
// carries out classified beats. Depends on bmmd_pkg.
module bmmd_back import bmmd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_entry      i_entry,
    output logic        o_boot_done,
    output logic [1:0]  o_page,
    output logic [1:0]  o_vbuf,
    output logic        o_clearing,
    output logic        o_done,
    output logic [7:0]  o_read_data,
    output logic [15:0] o_video_address,
    output logic        o_keyboard_written,
    output logic        o_video_mode_written,
    output logic        o_ram_page_written,
    output logic        o_video_buffer_written,
    output logic [7:0]  o_video_mode,
    output logic [7:0]  o_video_buffer,
    output logic [31:0] o_keyboard_out_port
);
    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001, S_EXEC = 4'b0010, S_FETCH = 4'b0100, S_DONE = 4'b1000
    } t_state;

    logic [7:0] ram0 [RAM_PAGE_DEPTH];
    logic [7:0] ram1 [RAM_PAGE_DEPTH];
    logic [7:0] rom  [ROM_DEPTH];
    logic [7:0] dsk  [ROM_DISK_DEPTH];

    t_state r_state;
    logic [RAM_AW:0] r_clr;
    logic [31:0] r_kin, r_kout, r_dsk, r_p6, r_p7;
    logic [7:0]  r_vmode, r_page, r_vbuf, r_spare, r_ram0_q, r_ram1_q, r_rom_q, r_dsk_q;
    logic        r_boot;
    logic [15:0] r_vaddr;
    t_entry      r_cur;
    logic [3:0]  r_flags, n_flags;
    logic [1:0]  r_sel;
    logic [31:0] port_word, n_dsk;
    logic [4:0]  sh;

    assign sh = {i_entry.addr[1:0], 3'b000};
    assign n_dsk = (r_dsk & ~(32'hFF << sh)) | ({24'd0, i_entry.data} << sh);

    always_comb begin
        unique case (r_sel)
            2'd0: port_word = r_kin;
            2'd1: port_word = r_dsk;
            2'd2: port_word = r_p6;
            default: port_word = r_p7;
        endcase
    end

    // Written-flags for the beat being executed.
    always_comb begin
        n_flags = '0;
        if (i_entry.cls == C_WR_PORT && i_entry.addr[9:8] == 2'd0) n_flags[0] = 1'b1;
        if (i_entry.cls == C_WR_CTRL) begin
            unique case (i_entry.addr[9:8])
                2'd0: n_flags[1] = 1'b1;
                2'd1: n_flags[2] = 1'b1;
                2'd2: n_flags[3] = 1'b1;
                default: ;
            endcase
        end
    end

    // Memories: registered read; the clear writes and the ROM disk reads use their own address.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            ram0[r_clr[RAM_AW-1:0]] <= 8'd0;
            ram1[r_clr[RAM_AW-1:0]] <= 8'd0;
        end else if (i_valid && i_entry.cls == C_WR_RAM0) begin
            ram0[i_entry.addr[RAM_AW-1:0]] <= i_entry.data;
        end else if (i_valid && i_entry.cls == C_WR_RAM1) begin
            ram1[i_entry.addr[RAM_AW-1:0]] <= i_entry.data;
        end
        r_ram0_q <= ram0[i_entry.addr[RAM_AW-1:0]];
        r_ram1_q <= ram1[i_entry.addr[RAM_AW-1:0]];
        if (i_valid && i_entry.cls == C_LD_ROM) begin
            rom[i_entry.addr[ROM_AW-1:0]] <= i_entry.data;
        end
        r_rom_q <= rom[i_entry.addr[ROM_AW-1:0]];
        if (i_valid && i_entry.cls == C_LD_DSK) begin
            dsk[i_entry.addr[DSK_AW-1:0]] <= i_entry.data;
        end
        r_dsk_q <= dsk[{r_dsk[23:16], r_dsk[15:8]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_kin <= WORD_FF; r_kout <= WORD_FF; r_dsk <= WORD_FF;
            r_p6  <= WORD_FF; r_p7   <= WORD_FF;
            r_vmode <= '0; r_page <= '0; r_vbuf <= '0; r_spare <= '0;
            r_boot <= 1'b0; r_vaddr <= '0;
            r_flags <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (RAM_AW+1)'(RAM_PAGE_DEPTH - 1)) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (i_valid) begin
                        r_cur   <= i_entry;
                        r_sel   <= i_entry.addr[9:8];
                        r_flags <= n_flags;
                        r_state <= (i_entry.cls == C_WR_PORT && i_entry.addr[9:8] == 2'd1)
                                   ? S_FETCH : S_DONE;
                        if (i_entry.vid_hit) r_vaddr <= i_entry.addr;
                        unique case (i_entry.cls)
                            C_SET_KBD: r_kin <= (r_kin & ~(32'hFF << sh)) |
                                                ({24'd0, i_entry.data} << sh);
                            C_WR_PORT: begin
                                unique case (i_entry.addr[9:8])
                                    2'd0: r_kout <= (r_kout & ~(32'hFF << sh)) |
                                                    ({24'd0, i_entry.data} << sh);
                                    2'd1: r_dsk <= n_dsk;
                                    2'd2: r_p6 <= (r_p6 & ~(32'hFF << sh)) |
                                                  ({24'd0, i_entry.data} << sh);
                                    default: r_p7 <= (r_p7 & ~(32'hFF << sh)) |
                                                     ({24'd0, i_entry.data} << sh);
                                endcase
                            end
                            C_WR_CTRL: begin
                                unique case (i_entry.addr[9:8])
                                    2'd0: begin
                                        r_vmode <= i_entry.data; r_boot <= 1'b1;
                                    end
                                    2'd1: r_page <= i_entry.data;
                                    2'd2: r_vbuf <= i_entry.data;
                                    default: r_spare <= i_entry.data;
                                endcase
                            end
                            default: ;
                        endcase
                    end
                end
                S_FETCH: begin
                    // The ROM disk address settled last cycle; the byte is registered
                    // at the end of this one.
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // A port F5 write ends by loading the fetched disk byte into byte 0.
                    if (r_cur.cls == C_WR_PORT && r_cur.addr[9:8] == 2'd1) begin
                        r_dsk[7:0] <= r_dsk_q;
                    end
                    r_state <= S_EXEC;
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    always_comb begin
        priority case (r_cur.cls)
            C_RD_ROM:  o_read_data = r_rom_q;
            C_RD_RAM0: o_read_data = r_ram0_q;
            C_RD_RAM1: o_read_data = r_ram1_q;
            C_RD_PORT: o_read_data = port_word[{r_cur.addr[1:0], 3'b000} +: 8];
            C_RD_FF:   o_read_data = BYTE_FF;
            default:   o_read_data = 8'd0;
        endcase
    end

    // Every beat shows its result during its single DONE cycle.
    assign o_done = (r_state == S_DONE);
    assign o_clearing = (r_state == S_CLEAR);
    assign o_boot_done = r_boot;
    assign o_page = r_page[1:0];
    assign o_vbuf = r_vbuf[1:0];
    assign o_video_address = r_vaddr;
    assign o_keyboard_written = r_flags[0];
    assign o_video_mode_written = r_flags[1];
    assign o_ram_page_written = r_flags[2];
    assign o_video_buffer_written = r_flags[3];
    assign o_video_mode = r_vmode;
    assign o_video_buffer = r_vbuf;
    assign o_keyboard_out_port = r_kout;
endmodule
